[hdl/isort_pkg.sv]
// ============================================================================
// isort_pkg
// Shared types and constants of the insertion sorter: the command flags that
// travel from the front end to the sort chain, and the back-end states.
// ============================================================================
package isort_pkg;

    // Width of the value ports on the block boundary.
    localparam int DATA_BITS = 32;

    // Depth of the command queue between the front end and the sort chain.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    // Flags that go with each queued value.
    typedef struct packed {
        logic ins;    // value goes into the chain
        logic last;   // final word of the batch
        logic ovf;    // batch has dropped at least one word so far
    } t_cmd_flags;

    localparam int CMD_FLAG_BITS = $bits(t_cmd_flags);

    // Sort chain states.
    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_back_state;

endpackage

[hdl/insertion_sorter_unit.sv]
// ============================================================================
// insertion_sorter_unit
// Sorts batches of signed values: each word that fits is inserted into an
// ascending chain, and the final word of a batch releases the held batch in order.
// ============================================================================
//
//  Channel   Handshake          Payload
//  -------   ----------------   ------------------------------------------
//  input     push / full        i_value, i_batch_end
//  result    empty / pop        o_sorted_value, o_final_result, o_overflowed
//
//  An input word is taken while push is high and full is low; while loading, the
//  chain inserts one queued word per cycle, so a batch streams in at one per cycle.
//  A batch of N held values leaves at one result per cycle while pop keeps up,
//  by the shift of the cell row; the chain takes no new command meanwhile, and
//  the four-entry command queue then fills until full rises.
//  Reset is synchronous and clears the counts, queue and output valid flag;
//  the cell contents and output data are not cleared.
//  A stalled result (pop low) holds in the output register and stops the drain.
//
module insertion_sorter_unit #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [isort_pkg::DATA_BITS-1:0] i_value,
    input  logic                            i_batch_end,
    output logic                            empty,
    input  logic                            pop,
    output logic [isort_pkg::DATA_BITS-1:0] o_sorted_value,
    output logic                            o_final_result,
    output logic                            o_overflowed
);
    import isort_pkg::*;

    localparam int CMD_BITS = VALUE_BITS + CMD_FLAG_BITS;

    logic                q_push;
    logic [CMD_BITS-1:0] q_wdata;
    logic                q_full;
    logic                q_pop;
    logic [CMD_BITS-1:0] q_rdata;
    logic                q_empty;

    assign full = q_full;

    // Front end: accept and classify.
    isort_front #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_value     (i_value),
        .i_batch_end (i_batch_end),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    // Command queue between the two sides.
    isort_queue #(
        .WIDTH (CMD_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // Back end: insertion chain and drain.
    isort_chain #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_chain (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_data       (q_rdata),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .empty          (empty),
        .pop            (pop),
        .o_sorted_value (o_sorted_value),
        .o_final_result (o_final_result),
        .o_overflowed   (o_overflowed)
    );

endmodule

[hdl/isort_queue.sv]
// ============================================================================
// isort_queue
// Short first-in first-out queue of commands between the front end and the
// sort chain, so that each side stalls on its own.
// ============================================================================
module isort_queue #(
    parameter int WIDTH = 35
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import isort_pkg::*;

    logic [WIDTH-1:0]     r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_fill;
    logic                 wr_en;
    logic                 rd_en;

    assign o_full  = (r_fill == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage is written at the write pointer only.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_fill <= r_fill + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

[hdl/isort_front.sv]
// ============================================================================
// isort_front
// Front end of the insertion sorter: accepts input words, decides whether
// each value still fits in the chain, and queues a command for the back end.
// ============================================================================
module isort_front #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    input  logic [isort_pkg::DATA_BITS-1:0]        i_value,
    input  logic                                   i_batch_end,
    input  logic                                   i_q_full,
    output logic                                   o_q_push,
    output logic [VALUE_BITS+isort_pkg::CMD_FLAG_BITS-1:0] o_q_data
);
    import isort_pkg::*;

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    logic [CNT_BITS-1:0]   r_fcount;
    logic                  r_fovf;
    logic [VALUE_BITS-1:0] value_int;
    t_cmd_flags            flags;
    logic                  accept;

    assign accept = push && !i_q_full;

    // Bring the port value to the internal width.
    generate
        if (VALUE_BITS <= DATA_BITS) begin : g_trunc
            assign value_int = i_value[VALUE_BITS-1:0];
        end else begin : g_ext
            assign value_int = {{(VALUE_BITS-DATA_BITS){1'b0}}, i_value};
        end
    endgenerate

    // Classify the word: insert it while the batch still has room.
    always_comb begin
        flags.ins  = (r_fcount != CNT_BITS'(CAPACITY));
        flags.last = i_batch_end;
        flags.ovf  = r_fovf || (r_fcount == CNT_BITS'(CAPACITY));
    end

    assign o_q_push = accept;
    assign o_q_data = {flags, value_int};

    // Per-batch fill count and overflow flag, cleared by the final word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcount <= '0;
            r_fovf   <= 1'b0;
        end else if (accept) begin
            if (i_batch_end) begin
                r_fcount <= '0;
                r_fovf   <= 1'b0;
            end else begin
                r_fcount <= r_fcount + CNT_BITS'(flags.ins);
                r_fovf   <= flags.ovf;
            end
        end
    end

endmodule

[hdl/isort_chain.sv]
// ============================================================================
// isort_chain
// Back end of the insertion sorter: a row of sorted cells that takes one value
// per cycle while loading and the queue is not empty, into its ascending place,
// then shifts the batch out through an output register, smallest value first.
// ============================================================================
module isort_chain #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [VALUE_BITS+isort_pkg::CMD_FLAG_BITS-1:0] i_q_data,
    input  logic                                   i_q_empty,
    output logic                                   o_q_pop,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [isort_pkg::DATA_BITS-1:0]        o_sorted_value,
    output logic                                   o_final_result,
    output logic                                   o_overflowed
);
    import isort_pkg::*;

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    t_back_state           r_state;
    t_back_state           n_state;
    logic [VALUE_BITS-1:0] r_cell [CAPACITY];
    logic [VALUE_BITS-1:0] ins_cell [CAPACITY];
    logic [CNT_BITS-1:0]   r_count;
    logic                  r_ovf;
    logic [CAPACITY-1:0]   lt;
    logic [VALUE_BITS-1:0] q_value;
    t_cmd_flags            q_flags;
    logic                  do_ins;
    logic                  do_drain;
    logic                  out_take;

    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic                  r_out_final;
    logic                  r_out_ovf;

    assign q_value  = i_q_data[VALUE_BITS-1:0];
    assign q_flags  = t_cmd_flags'(i_q_data[VALUE_BITS +: CMD_FLAG_BITS]);
    assign out_take = !r_out_valid || pop;

    // Each cell compares the new value; empty cells count as larger.
    // Equal values stay ahead of the new one.
    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            assign lt[i] = (CNT_BITS'(i) >= r_count) ||
                           ($signed(q_value) < $signed(r_cell[i]));
            if (i == 0) begin : g_head
                assign ins_cell[i] = lt[i] ? q_value : r_cell[i];
            end else begin : g_body
                assign ins_cell[i] = lt[i-1] ? r_cell[i-1] :
                                     (lt[i] ? q_value : r_cell[i]);
            end
        end
    endgenerate

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: load commands until a final word, then drain the batch.
    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        do_ins   = 1'b0;
        do_drain = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    do_ins  = q_flags.ins;
                    if (q_flags.last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_take) begin
                    do_drain = 1'b1;
                    if (r_count == CNT_BITS'(1)) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Cell contents: insert, or shift down toward the head while draining.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (do_ins) begin
                r_cell[i] <= ins_cell[i];
            end else if (do_drain && (i < CAPACITY - 1)) begin
                r_cell[i] <= r_cell[(i + 1) % CAPACITY];
            end
        end
    end

    // Held count and the batch overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (do_ins) begin
                r_count <= r_count + 1'b1;
            end else if (do_drain) begin
                r_count <= r_count - 1'b1;
            end
            if (o_q_pop && q_flags.last) begin
                r_ovf <= q_flags.ovf;
            end
        end
    end

    // Output register holds one result word until it is popped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_drain) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_drain) begin
            r_out_value <= r_cell[0];
            r_out_final <= (r_count == CNT_BITS'(1));
            r_out_ovf   <= r_ovf;
        end
    end

    assign empty          = !r_out_valid;
    assign o_final_result = r_out_final;
    assign o_overflowed   = r_out_ovf;

    // Results leave as the low bits of the port, zero-extended if narrower, else truncated.
    generate
        if (VALUE_BITS >= DATA_BITS) begin : g_out_trunc
            assign o_sorted_value = r_out_value[DATA_BITS-1:0];
        end else begin : g_out_ext
            assign o_sorted_value = {{(DATA_BITS-VALUE_BITS){1'b0}}, r_out_value};
        end
    endgenerate

    // The chain never holds more than its capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY))
        else $error("sort chain count above capacity");

    // A batch being drained always has at least one value left.
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_count != '0))
        else $error("draining an empty sort chain");

    // Emitting the final word returns the chain to loading, empty.
    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_drain && r_count == CNT_BITS'(1)) |=>
            (r_state == ST_LOAD && r_count == '0 && r_out_final))
        else $error("final word did not end the batch");

    // No command is taken from the queue while a batch drains.
    a_no_pop_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> !o_q_pop)
        else $error("queue popped during drain");

endmodule
